// ===== rtl/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// cdq_pkg
// shared types, sizes and codes of the circular deque
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

  localparam int DEPTH      = 8;
  localparam int DATA_WIDTH = 32;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_BACK  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_BACK   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_t;

  typedef struct packed {
    logic accept;
    logic load_direct;
    logic load_ram;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } stat_t;

  function automatic ptr_t ptr_up(input ptr_t p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic ptr_t ptr_down(input ptr_t p);
    return (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cdq_ram.sv =====
// ----------------------------------------------------------------------------
// cdq_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdq_ctrl
// handshake controller: accepts words, sequences ram reads, owns output valid
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output      logic            s_tready,
  output      logic            m_tvalid,
  input  wire logic            m_tready,
  input  wire cdq_pkg::action_t action,
  input  wire cdq_pkg::stat_t  stat,
  output      cdq_pkg::cmd_t   cmd
);

  import cdq_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   out_valid_next;
  logic   out_free;
  logic   is_pop;
  logic   accept;

  assign out_free = !out_valid || m_tready;
  assign is_pop   = (action == ACT_POP_FRONT) || (action == ACT_POP_BACK);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && is_pop && !stat.empty) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready        = 1'b0;
    cmd.accept      = 1'b0;
    cmd.load_direct = 1'b0;
    cmd.load_ram    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready        = out_free;
        cmd.accept      = s_tvalid && out_free;
        cmd.load_direct = s_tvalid && out_free && !(is_pop && !stat.empty);
      end
      ST_READ: begin
        cmd.load_ram = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.load_direct || cmd.load_ram) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  assign m_tvalid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cdq_datapath.sv =====
// ----------------------------------------------------------------------------
// cdq_datapath
// ring pointers, entry count, ring ram and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_datapath (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cdq_pkg::cmd_t    cmd,
  input  wire cdq_pkg::action_t action,
  input  wire logic [31:0]      push_value,
  output      cdq_pkg::stat_t   stat,
  output      logic [31:0]      pop_value,
  output      cdq_pkg::status_t status,
  output      logic [3:0]       occupancy
);

  import cdq_pkg::*;

  ptr_t                  head;
  ptr_t                  head_next;
  ptr_t                  tail;
  ptr_t                  tail_next;
  cnt_t                  count;
  cnt_t                  count_next;
  logic                  wr_en;
  ptr_t                  wr_addr;
  logic                  rd_en;
  ptr_t                  rd_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [31:0]           res_value;
  status_t               res_status;

  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);
  assign wr_data    = DATA_WIDTH'(push_value);

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    wr_en      = 1'b0;
    wr_addr    = head;
    rd_en      = 1'b0;
    rd_addr    = head;
    res_value  = '0;
    res_status = STATUS_OK;
    unique case (action)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (stat.full) begin
          res_status = STATUS_OVERFLOW;
        end else begin
          wr_en      = cmd.accept;
          count_next = count + 1'b1;
          if (stat.empty) begin
            tail_next = head;
            wr_addr   = head;
          end else if (action == ACT_PUSH_FRONT) begin
            head_next = ptr_down(head);
            wr_addr   = ptr_down(head);
          end else begin
            tail_next = ptr_up(tail);
            wr_addr   = ptr_up(tail);
          end
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK: begin
        if (stat.empty) begin
          res_value  = '1;
          res_status = STATUS_UNDERFLOW;
        end else begin
          rd_en      = cmd.accept;
          count_next = count - 1'b1;
          if (action == ACT_POP_FRONT) begin
            rd_addr   = head;
            head_next = ptr_up(head);
          end else begin
            rd_addr   = tail;
            tail_next = ptr_down(tail);
          end
        end
      end
      default: ;
    endcase
  end

  cdq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= PTR_W'(DEPTH - 1);
      count <= '0;
    end else if (cmd.accept) begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_direct) begin
      pop_value <= res_value;
      status    <= res_status;
      occupancy <= 4'(count_next);
    end else if (cmd.load_ram) begin
      pop_value <= 32'(rd_data);
      status    <= STATUS_OK;
      occupancy <= 4'(count);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/circular_deque.sv =====
// ----------------------------------------------------------------------------
// circular_deque
// double-ended queue of DEPTH words kept in a ring ram
// ----------------------------------------------------------------------------
// Each input word requests push front, push back, pop front or pop back and
// yields exactly one output word with the popped value, a status (ok,
// overflow, underflow) and the occupancy after the operation. Pushes,
// overflows and underflows complete at the accepting edge, so with the
// output taken every cycle the block sustains one such word per cycle. A
// successful pop reads the ring ram through its registered read port, then
// the word is loaded into the result register, and no new word is accepted
// meanwhile. The ring is not cleared after reset; pops only ever read
// entries already written by a push.
`default_nettype none

module circular_deque (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [39:0] s_tdata,  // action[1:0], push_value[33:2], zero pad
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [39:0] m_tdata   // pop_value[31:0], status[33:32],
                                     // occupancy[37:34], zero pad
);

  import cdq_pkg::*;

  action_t     action;
  logic [31:0] push_value;
  cmd_t        cmd;
  stat_t       stat;
  logic [31:0] pop_value;
  status_t     status;
  logic [3:0]  occupancy;

  assign action     = action_t'(s_tdata[1:0]);
  assign push_value = s_tdata[33:2];

  cdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .action   (action),
    .stat     (stat),
    .cmd      (cmd)
  );

  cdq_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .action     (action),
    .push_value (push_value),
    .stat       (stat),
    .pop_value  (pop_value),
    .status     (status),
    .occupancy  (occupancy)
  );

  assign m_tdata = {2'b00, occupancy, status, pop_value};

  // queue can never be full and empty at once
  assert property (@(posedge clk) disable iff (rst) !(stat.full && stat.empty))
    else $error("full and empty together");

  // a pop that reads the ram blocks the input for the following cycle
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && action[1] && !stat.empty) |=> !s_tready)
    else $error("input accepted during ram read");

  // ram data is loaded only while no input word is being taken
  assert property (@(posedge clk) disable iff (rst)
    cmd.load_ram |-> !(s_tready || cmd.load_direct))
    else $error("ram load overlaps an accept");

  // an underflow always reports an empty queue
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && status == STATUS_UNDERFLOW) |-> (occupancy == 4'd0))
    else $error("underflow with nonzero occupancy");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque testbench
// drives a directed sequence, then random push and pop words at both ends of the
// deque with random gaps and output stalls, mirrors the ring in a scoreboard and
// checks every output word field by field against the mirror
// ----------------------------------------------------------------------------

module testbench;

  import cdq_pkg::*;

  typedef struct {
    logic [31:0] pop_value;
    status_t     status;
    cnt_t        occupancy;
  } reply_t;

  class deque_mirror;
    logic [DATA_WIDTH-1:0] ring [DEPTH];
    ptr_t                  head;
    ptr_t                  tail;
    cnt_t                  count;
    reply_t                pending_replies [$];
    int                    mismatches;

    function new();
      head       = '0;
      tail       = PTR_W'(DEPTH - 1);
      count      = '0;
      mismatches = 0;
    endfunction

    function void note_request(input action_t act, input logic [31:0] val);
      reply_t r;
      r.pop_value = '0;
      r.status    = STATUS_OK;
      if (act == ACT_PUSH_FRONT || act == ACT_PUSH_BACK) begin
        if (count == cnt_t'(DEPTH)) begin
          r.status = STATUS_OVERFLOW;
        end else begin
          // first entry: both ends name it
          if (count == '0) begin
            tail = head;
          end else if (act == ACT_PUSH_FRONT) begin
            head = (head == '0) ? PTR_W'(DEPTH - 1) : head - 1'b1;
          end else begin
            tail = (tail == PTR_W'(DEPTH - 1)) ? '0 : tail + 1'b1;
          end
          ring[(act == ACT_PUSH_FRONT) ? head : tail] = val[DATA_WIDTH-1:0];
          count = count + 1'b1;
        end
      end else if (count == '0) begin
        r.status    = STATUS_UNDERFLOW;
        r.pop_value = '1;
      end else begin
        if (act == ACT_POP_FRONT) begin
          r.pop_value = 32'(ring[head]);
          head = (head == PTR_W'(DEPTH - 1)) ? '0 : head + 1'b1;
        end else begin
          r.pop_value = 32'(ring[tail]);
          tail = (tail == '0) ? PTR_W'(DEPTH - 1) : tail - 1'b1;
        end
        count = count - 1'b1;
      end
      r.occupancy = count;
      pending_replies.insert(pending_replies.size(), r);
    endfunction

    function void check_reply(input logic [39:0] word);
      reply_t r;
      if (pending_replies.size() == 0) begin
        $error("result word with no request waiting: %h", word);
        mismatches++;
        return;
      end
      r = pending_replies[0];
      pending_replies.delete(0);
      if (word[31:0] !== r.pop_value) begin
        $error("pop_value: expected %h, got %h", r.pop_value, word[31:0]);
        mismatches++;
      end
      if (word[33:32] !== r.status) begin
        $error("status: expected %0d, got %0d", r.status, word[33:32]);
        mismatches++;
      end
      if (word[37:34] !== r.occupancy) begin
        $error("occupancy: expected %0d, got %0d", r.occupancy, word[37:34]);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;

  deque_mirror mirror;
  bit          no_gaps;
  int          words_sent;

  circular_deque dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("circular_deque regression: fail");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input action_t act, input logic [31:0] val);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, val, act};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    mirror.note_request(act, val);
    words_sent++;
  endtask

  task automatic run_directed();
    // pops on empty at both ends
    send_word(ACT_POP_FRONT, 32'h1234_5678);
    send_word(ACT_POP_BACK, 32'hffff_ffff);
    // single entry reached from either end
    send_word(ACT_PUSH_FRONT, 32'h7fff_ffff);
    send_word(ACT_POP_BACK, 32'h0);
    send_word(ACT_PUSH_BACK, 32'h8000_0000);
    send_word(ACT_POP_FRONT, 32'h0);
    // fill to full with both ends, wrapping the indices
    send_word(ACT_PUSH_FRONT, 32'h0000_0000);
    send_word(ACT_PUSH_BACK, 32'hffff_ffff);
    send_word(ACT_PUSH_FRONT, 32'h5555_5555);
    send_word(ACT_PUSH_BACK, 32'haaaa_aaaa);
    send_word(ACT_PUSH_FRONT, 32'h8000_0000);
    send_word(ACT_PUSH_BACK, 32'h7fff_ffff);
    send_word(ACT_PUSH_FRONT, 32'h0000_0001);
    send_word(ACT_PUSH_BACK, 32'hfffe_0000);
    // overflow at both ends
    send_word(ACT_PUSH_FRONT, 32'hdead_beef);
    send_word(ACT_PUSH_BACK, 32'hcafe_f00d);
    repeat (4) begin
      send_word(ACT_POP_FRONT, 32'h0);
      send_word(ACT_POP_BACK, 32'h0);
    end
    send_word(ACT_POP_BACK, 32'h0);
  endtask

  task automatic run_random(input int total);
    int  seg_len;
    int  push_pct;
    bit  is_push;
    bit  at_front;
    while (words_sent < total) begin
      seg_len = $urandom_range(5, 40);
      case ($urandom_range(0, 3))
        0: push_pct = 85;
        1: push_pct = 15;
        default: push_pct = 50;
      endcase
      no_gaps = ($urandom_range(0, 4) == 0);
      repeat (seg_len) begin
        is_push  = ($urandom_range(0, 99) < push_pct);
        at_front = 1'($urandom_range(0, 1));
        if (is_push)
          send_word(at_front ? ACT_PUSH_FRONT : ACT_PUSH_BACK, pick_value());
        else
          send_word(at_front ? ACT_POP_FRONT : ACT_POP_BACK, pick_value());
      end
    end
    no_gaps = 1'b0;
  endtask

  // output stalls
  initial begin
    int run;
    int stall;
    m_tready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      m_tready <= 1'b1;
      run = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      repeat (run) @(posedge clk);
      stall = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 3);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst === 1'b0 && m_tvalid && m_tready)
      mirror.check_reply(m_tdata);
  end

  initial begin
    mirror     = new();
    no_gaps    = 1'b0;
    words_sent = 0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    run_random(words_sent + 1250);
    s_tvalid <= 1'b0;
    while (mirror.pending_replies.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mirror.mismatches == 0)
      $display("circular_deque regression: pass");
    else
      $display("circular_deque regression: fail");
    $finish;
  end

endmodule
